[src/spq_pkg.sv]
// Shared constants, codes and types for the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int CAPACITY      = 128;
	localparam int DATA_BITS     = 32;
	localparam int PRIORITY_BITS = 16;
	localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

	// Request operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic signed [DATA_BITS-1:0]     data;
		logic signed [PRIORITY_BITS-1:0] prio;
	} entry_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t entry;
	} cmd_t;

endpackage

`default_nettype wire

[src/spq_cell.sv]
// One slot of the sorted row: holds an entry and shifts or inserts per command.
`default_nettype none

module spq_cell (
	input  wire logic           clk,
	input  wire spq_pkg::cmd_t  cmd,
	input  wire logic           occupied,
	input  wire logic           prev_behind,
	input  wire spq_pkg::entry_t left_entry,
	input  wire spq_pkg::entry_t right_entry,
	output logic                behind,
	output spq_pkg::entry_t     entry
);

	spq_pkg::entry_t entry_q;

	// New entry goes behind this one when stored priority is equal or higher
	assign behind = occupied && ($signed(entry_q.prio) >= $signed(cmd.entry.prio));
	assign entry  = entry_q;

	// Keep, take the new entry, shift right on insert, shift left on removal
	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!prev_behind) begin
				entry_q <= left_entry;
			end else if (!behind) begin
				entry_q <= cmd.entry;
			end
		end else if (cmd.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

[src/sorted_priority_queue.sv]
// Top level: bounded priority queue built as a row of sorting cells.
// Result: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle while in_stall is low; every cell
// compares against the new priority and shifts with its neighbors in the
// same cycle. Reset: entry count and result valid clear at once; cell
// contents are undefined until written, and no clearing pass is needed.
`default_nettype none

module sorted_priority_queue (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_stall,
	input  wire logic                                       op,
	input  wire logic signed [spq_pkg::DATA_BITS-1:0]       item_data,
	input  wire logic signed [spq_pkg::PRIORITY_BITS-1:0]   item_priority,
	output logic                                            out_valid,
	input  wire logic                                       out_stall,
	output logic [1:0]                                      status,
	output logic signed [spq_pkg::DATA_BITS-1:0]            out_data,
	output logic signed [spq_pkg::PRIORITY_BITS-1:0]        out_priority
);

	localparam int CAP = spq_pkg::CAPACITY;
	localparam int CB  = spq_pkg::COUNT_BITS;

	logic [CB-1:0]   count_q;
	logic            out_valid_q;
	logic [1:0]      status_q;
	logic signed [spq_pkg::DATA_BITS-1:0]     data_q;
	logic signed [spq_pkg::PRIORITY_BITS-1:0] prio_q;

	logic            fire;
	logic            full;
	logic            empty;
	spq_pkg::cmd_t   cmd;
	logic [CAP-1:0]  behind;
	spq_pkg::entry_t cell_entry [CAP];

	// Request handshake: accept while the result register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign fire     = in_valid && !in_stall;
	assign full     = (count_q == CB'(CAP));
	assign empty    = (count_q == '0);

	// Command to the row; overflow and underflow leave the row untouched
	always_comb begin
		cmd.enq        = fire && (op == spq_pkg::OP_ENQ) && !full;
		cmd.deq        = fire && (op == spq_pkg::OP_DEQ) && !empty;
		cmd.entry.data = item_data;
		cmd.entry.prio = item_priority;
	end

	// Row of cells
	genvar gi;
	generate
		for (gi = 0; gi < CAP; gi++) begin : g_cell
			localparam logic [CB-1:0] IDX = CB'(gi);
			logic            prev_b;
			spq_pkg::entry_t left_e;
			spq_pkg::entry_t right_e;

			if (gi == 0) begin : g_first
				assign prev_b = 1'b1;
				assign left_e = cmd.entry;
			end else begin : g_mid
				assign prev_b = behind[gi-1];
				assign left_e = cell_entry[gi-1];
			end
			if (gi == CAP - 1) begin : g_last
				assign right_e = cmd.entry;
			end else begin : g_inner
				assign right_e = cell_entry[gi+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (IDX < count_q),
				.prev_behind (prev_b),
				.left_entry  (left_e),
				.right_entry (right_e),
				.behind      (behind[gi]),
				.entry       (cell_entry[gi])
			);
		end
	endgenerate

	// Entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.enq) begin
				count_q <= count_q + CB'(1);
			end else if (cmd.deq) begin
				count_q <= count_q - CB'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			if (op == spq_pkg::OP_ENQ) begin
				status_q <= full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_OK;
				data_q   <= '0;
				prio_q   <= '0;
			end else if (empty) begin
				status_q <= spq_pkg::ST_UNDERFLOW;
				data_q   <= '1;
				prio_q   <= '1;
			end else begin
				status_q <= spq_pkg::ST_OK;
				data_q   <= cell_entry[0].data;
				prio_q   <= cell_entry[0].prio;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_data     = data_q;
	assign out_priority = prio_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(CAP))
		else $error("entry count above capacity");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> (count_q == $past(count_q) + CB'(1)))
		else $error("insert did not raise entry count");

	a_underflow_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == spq_pkg::ST_UNDERFLOW) |->
		(data_q == '1 && prio_q == '1))
		else $error("underflow result not all ones");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CB'(2)) |->
		($signed(cell_entry[0].prio) >= $signed(cell_entry[1].prio)))
		else $error("front entries out of order");

endmodule

`default_nettype wire

[bench/tb_sorted_priority_queue.sv]
// Self-checking testbench for the sorted priority queue: random and directed requests.
module tb_sorted_priority_queue;

	localparam int REQUEST_TARGET = 1550;
	localparam int STUCK_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct {
		logic                                     op;
		logic signed [spq_pkg::DATA_BITS-1:0]     data;
		logic signed [spq_pkg::PRIORITY_BITS-1:0] prio;
	} request_t;

	typedef struct {
		logic [1:0]                               status;
		logic signed [spq_pkg::DATA_BITS-1:0]     data;
		logic signed [spq_pkg::PRIORITY_BITS-1:0] prio;
	} result_t;

	logic                                     clk = 1'b0;
	logic                                     arst_n = 1'b0;
	logic                                     in_valid = 1'b0;
	logic                                     in_stall;
	logic                                     op = spq_pkg::OP_ENQ;
	logic signed [spq_pkg::DATA_BITS-1:0]     item_data = '0;
	logic signed [spq_pkg::PRIORITY_BITS-1:0] item_priority = '0;
	logic                                     out_valid;
	logic                                     out_stall = 1'b0;
	logic [1:0]                               status;
	logic signed [spq_pkg::DATA_BITS-1:0]     out_data;
	logic signed [spq_pkg::PRIORITY_BITS-1:0] out_priority;

	request_t         pending_requests[$];
	result_t          due_results[$];
	spq_pkg::entry_t  held_entries[$];   // queue contents, front = highest priority

	int request_total;
	int accepted_count;
	int err_count;
	int stuck_cycles;

	sorted_priority_queue DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.item_data    (item_data),
		.item_priority(item_priority),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_data     (out_data),
		.out_priority (out_priority)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Idle percentage per side: three phases over the run
	function automatic int idle_pct(bit sender);
		if (accepted_count < request_total / 3)
			return sender ? 17 : 52;
		if (accepted_count < (2 * request_total) / 3)
			return sender ? 52 : 17;
		return 0;
	endfunction

	function automatic void add_request(logic o, logic signed [spq_pkg::DATA_BITS-1:0] d,
			logic signed [spq_pkg::PRIORITY_BITS-1:0] p);
		request_t r;
		r.op   = o;
		r.data = d;
		r.prio = p;
		pending_requests.push_back(r);
	endfunction

	function automatic logic signed [spq_pkg::PRIORITY_BITS-1:0] pick_priority();
		case ($urandom_range(9))
			0: return {1'b1, {(spq_pkg::PRIORITY_BITS-1){1'b0}}};
			1: return {1'b0, {(spq_pkg::PRIORITY_BITS-1){1'b1}}};
			2, 3, 4: return spq_pkg::PRIORITY_BITS'($urandom);
			default: return spq_pkg::PRIORITY_BITS'(int'($urandom_range(6)) - 3);   // many ties
		endcase
	endfunction

	// Queue behavior: sorted insert behind equal priorities, remove from front
	function automatic void predict_result(logic o, logic signed [spq_pkg::DATA_BITS-1:0] d,
			logic signed [spq_pkg::PRIORITY_BITS-1:0] p);
		result_t         res;
		spq_pkg::entry_t ent;
		int              pos;
		if (o == spq_pkg::OP_ENQ) begin
			res.data = '0;
			res.prio = '0;
			if (held_entries.size() >= spq_pkg::CAPACITY) begin
				res.status = spq_pkg::ST_OVERFLOW;
			end else begin
				res.status = spq_pkg::ST_OK;
				pos = held_entries.size();
				while (pos > 0 && $signed(held_entries[pos-1].prio) < $signed(p))
					pos--;
				ent.data = d;
				ent.prio = p;
				held_entries.insert(pos, ent);
			end
		end else if (held_entries.size() == 0) begin
			res.status = spq_pkg::ST_UNDERFLOW;
			res.data   = '1;
			res.prio   = '1;
		end else begin
			ent        = held_entries.pop_front();
			res.status = spq_pkg::ST_OK;
			res.data   = ent.data;
			res.prio   = ent.prio;
		end
		due_results.push_back(res);
	endfunction

	function automatic void report_error(string msg);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t req;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			op            <= spq_pkg::OP_ENQ;
			item_data     <= '0;
			item_priority <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_result(op, item_data, item_priority);
				accepted_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					req = pending_requests.pop_front();
					in_valid      <= 1'b1;
					op            <= req.op;
					item_data     <= req.data;
					item_priority <= req.prio;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < idle_pct(1'b0));
	end

	// Result monitor
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				report_error($sformatf("unexpected result status=%0d data=%0d prio=%0d",
					status, out_data, out_priority));
			end else begin
				want = due_results.pop_front();
				if (status !== want.status || out_data !== want.data ||
						out_priority !== want.prio)
					report_error($sformatf({"mismatch: status %0d/%0d data %0d/%0d ",
						"prio %0d/%0d (expected/actual)"}, want.status, status,
						want.data, out_data, want.prio, out_priority));
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin : main
		int n;
		int len;
		int enq_pct;
		int kind;

		// Directed: underflow, extremes, ties leaving in arrival order
		add_request(spq_pkg::OP_DEQ, 32'h1234_5678, 16'h7fff);
		add_request(spq_pkg::OP_ENQ, 32'h7fff_ffff, 16'sd0);
		add_request(spq_pkg::OP_ENQ, 32'h8000_0000, 16'h8000);
		add_request(spq_pkg::OP_ENQ, 32'd0, 16'h7fff);
		add_request(spq_pkg::OP_ENQ, 32'hffff_ffff, 16'sd0);
		add_request(spq_pkg::OP_ENQ, 32'd1, -16'sd1);
		add_request(spq_pkg::OP_ENQ, 32'd2, 16'sd1);
		add_request(spq_pkg::OP_ENQ, 32'd3, 16'h8000);
		for (int i = 0; i < 8; i++)
			add_request(spq_pkg::OP_DEQ, $urandom, spq_pkg::PRIORITY_BITS'($urandom));
		add_request(spq_pkg::OP_ENQ, 32'h5555_5555, 16'h5555);
		add_request(spq_pkg::OP_ENQ, 32'haaaa_aaaa, 16'haaaa);
		add_request(spq_pkg::OP_DEQ, 32'hffff_ffff, 16'hffff);
		add_request(spq_pkg::OP_DEQ, 32'h0, 16'h0);

		// Random bursts: fill past capacity, drain past empty, or mixed traffic
		n = pending_requests.size();
		while (n < REQUEST_TARGET) begin
			kind = $urandom_range(9);
			if (kind == 0) begin
				len = $urandom_range(spq_pkg::CAPACITY + 12, spq_pkg::CAPACITY + 2);
				enq_pct = 100;
			end else if (kind == 1) begin
				len = $urandom_range(spq_pkg::CAPACITY + 12, spq_pkg::CAPACITY + 2);
				enq_pct = 0;
			end else begin
				len = $urandom_range(40, 1);
				enq_pct = $urandom_range(75, 30);
			end
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < enq_pct)
					add_request(spq_pkg::OP_ENQ, $urandom, pick_priority());
				else
					add_request(spq_pkg::OP_DEQ, $urandom,
						spq_pkg::PRIORITY_BITS'($urandom));
			end
			n += len;
		end
		request_total = pending_requests.size();

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sorted_priority_queue.f]
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
